### rtl/core/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types and constants of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned FreeSlotsDef = 16;
  localparam int unsigned AddrBitsDef  = 16;
  localparam int unsigned SizeW        = 16;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [CfgIdxW-1:0] CfgMemSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFit     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinSl   = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StBad   = 2'd3;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  localparam logic [15:0] MemSizeRst = 16'd1024;
  localparam logic [15:0] MinSlRst   = 16'd10;

  // controller to datapath
  typedef struct packed {
    logic init;      // reload table with one extent, none if size is 0
    logic load;      // capture the input item
    logic scan_clr;  // restart the scan pointer
    logic scan_step; // examine one entry, advance pointer
    logic decide;    // evaluate the item, set status and plan
    logic shift_step;// move one entry for remove or insert
    logic commit;    // write the final entry update
  } vpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_shift;
    logic shift_done;
  } vpa_sts_t;

endpackage

### rtl/core/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl
// sequencer: load, scan, decide, shift, commit, respond
// ----------------------------------------------------------------------------
module vpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_init_i,
  output vpa_pkg::vpa_cmd_t cmd_o,
  input  vpa_pkg::vpa_sts_t sts_i
);
  import vpa_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SDec   = 3'd2;
  localparam logic [2:0] SShift = 3'd3;
  localparam logic [2:0] SComm  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       acc;

  // one item in flight; a new one waits until the result slot is free
  assign in_stall  = (state_q != SIdle) || (ov_q && out_stall);
  assign acc       = in_valid && !in_stall;
  assign out_valid = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.init = cfg_init_i;
    if (ov_q && !out_stall) ov_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (acc) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = SScan;
        end
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = SDec;
      end
      SDec: begin
        cmd_o.decide = 1'b1;
        state_d = SShift;
      end
      SShift: begin
        if (sts_i.need_shift && !sts_i.shift_done) cmd_o.shift_step = 1'b1;
        else state_d = SComm;
      end
      SComm: begin
        cmd_o.commit = 1'b1;
        ov_d    = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule

### rtl/core/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp
// free extent table, scan unit, shifter and result registers
// ----------------------------------------------------------------------------
module vpa_dp #(
  parameter int unsigned FreeSlots = vpa_pkg::FreeSlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vpa_pkg::vpa_cmd_t cmd_i,
  output vpa_pkg::vpa_sts_t sts_o,
  input  logic [15:0]       pool_size_i,
  input  logic [1:0]        fit_policy_i,
  input  logic [15:0]       min_slice_i,
  input  logic              mode_i,
  input  logic [15:0]       req_size_i,
  input  logic [15:0]       block_addr_i,
  output logic [1:0]        status_o,
  output logic [15:0]       grant_addr_o,
  output logic [15:0]       grant_size_o
);
  import vpa_pkg::*;

  localparam int unsigned IdxW = $clog2(FreeSlots);
  localparam int unsigned CntW = $clog2(FreeSlots + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(FreeSlots);
  localparam logic [AddrBitsDef-1:0] AMask = {AddrBitsDef{1'b1}};

  // table registers, each entry read at the scan pointer or fixed neighbors
  logic [15:0] st_q [FreeSlots];
  logic [15:0] ln_q [FreeSlots];
  logic [CntW-1:0] cnt_q;

  logic        mode_q;
  logic [15:0] size_q, addr_q;
  logic [CntW-1:0] ptr_q;
  logic        found_q;
  logic [IdxW-1:0] pick_q;
  logic [15:0] pick_len_q;
  logic [CntW-1:0] pos_q;
  logic [1:0]  status_q;
  logic [15:0] ga_q, gs_q;

  // plan
  localparam logic [1:0] PNone = 2'd0;
  localparam logic [1:0] PRem  = 2'd1; // remove entry at sh_idx
  localparam logic [1:0] PIns  = 2'd2; // insert at sh_idx
  logic [1:0]  plan_q;
  logic [CntW-1:0] sh_idx_q, sh_ptr_q;
  logic        wr_q;
  logic [IdxW-1:0] wr_idx_q;
  logic [15:0] wr_st_q, wr_ln_q;

  logic [IdxW-1:0] pi;
  logic [15:0] cur_st, cur_ln;
  assign pi     = ptr_q[IdxW-1:0];
  assign cur_st = st_q[pi];
  assign cur_ln = ln_q[pi];

  logic scan_done;
  always_comb begin
    if (ptr_q >= cnt_q) scan_done = 1'b1;
    else if (mode_q) scan_done = (cur_st >= addr_q);
    else scan_done = found_q && (fit_policy_i != FitBest) && (fit_policy_i != FitWorst);
  end

  // decide-stage reads around pos / pick
  logic [IdxW-1:0] pos_i, posm_i, pick_i;
  logic [15:0] p_st, p_ln, n_st, n_ln, k_st, k_ln;
  logic [16:0] p_end, f_end;
  logic [15:0] rem;
  logic has_prev, has_next;
  assign pos_i  = pos_q[IdxW-1:0];
  assign posm_i = pos_i - 1'b1;
  assign pick_i = pick_q;
  assign p_st = st_q[posm_i];
  assign p_ln = ln_q[posm_i];
  assign n_st = st_q[pos_i];
  assign n_ln = ln_q[pos_i];
  assign k_st = st_q[pick_i];
  assign k_ln = ln_q[pick_i];
  assign p_end = {1'b0, p_st} + {1'b0, p_ln};
  assign f_end = {1'b0, addr_q} + {1'b0, size_q};
  assign rem   = k_ln - size_q;
  assign has_prev = pos_q != '0;
  assign has_next = pos_q < cnt_q;

  logic [IdxW-1:0] shi, shn;
  assign shi = sh_ptr_q[IdxW-1:0];

  assign sts_o.scan_done  = scan_done;
  assign sts_o.need_shift = plan_q != PNone;
  always_comb begin
    shn = shi + 1'b1;
    if (plan_q == PRem) sts_o.shift_done = (sh_ptr_q + 1'b1 >= cnt_q);
    else sts_o.shift_done = (sh_ptr_q <= sh_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(1);
    end else if (cmd_i.init) begin
      cnt_q <= (pool_size_i != '0) ? CntW'(1) : '0;
    end else if (cmd_i.shift_step && plan_q == PRem) begin
      if (sh_ptr_q + 1'b1 >= cnt_q) cnt_q <= cnt_q - 1'b1;
    end else if (cmd_i.commit && plan_q == PRem) begin
      cnt_q <= cnt_q - 1'b1;
    end else if (cmd_i.commit && plan_q == PIns) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // one extent covering the whole pool
      for (int i = 0; i < FreeSlots; i++) begin
        st_q[i] <= '0;
        ln_q[i] <= (i == 0) ? MemSizeRst : '0;
      end
      mode_q     <= 1'b0;
      size_q     <= '0;
      addr_q     <= '0;
      ptr_q      <= '0;
      found_q    <= 1'b0;
      pick_q     <= '0;
      pick_len_q <= '0;
      pos_q      <= '0;
      status_q   <= StOk;
      ga_q       <= '0;
      gs_q       <= '0;
      plan_q     <= PNone;
      sh_idx_q   <= '0;
      sh_ptr_q   <= '0;
      wr_q       <= 1'b0;
      wr_idx_q   <= '0;
      wr_st_q    <= '0;
      wr_ln_q    <= '0;
    end else begin
      if (cmd_i.init) begin
        st_q[0] <= '0;
        ln_q[0] <= pool_size_i;
      end
      if (cmd_i.load) begin
        mode_q <= mode_i;
        size_q <= req_size_i;
        addr_q <= block_addr_i;
        ptr_q  <= '0;
        found_q <= 1'b0;
        pick_q <= '0;
        pick_len_q <= '0;
      end
      if (cmd_i.scan_step) begin
        if (!scan_done) begin
          ptr_q <= ptr_q + 1'b1;
          if (!mode_q && cur_ln >= size_q) begin
            if (!found_q) begin
              found_q <= 1'b1; pick_q <= pi; pick_len_q <= cur_ln;
            end else if ((fit_policy_i == FitBest && cur_ln < pick_len_q) ||
                         (fit_policy_i == FitWorst && cur_ln > pick_len_q)) begin
              pick_q <= pi; pick_len_q <= cur_ln;
            end
          end
        end else begin
          pos_q <= ptr_q;
        end
      end
      if (cmd_i.decide) begin
        plan_q   <= PNone;
        wr_q     <= 1'b0;
        ga_q     <= '0;
        gs_q     <= '0;
        status_q <= StOk;
        if (!mode_q) begin
          if (size_q == '0) status_q <= StBad;
          else if (!found_q) status_q <= StNoFit;
          else begin
            ga_q <= k_st;
            if (rem > min_slice_i) begin
              gs_q <= size_q;
              wr_q <= 1'b1; wr_idx_q <= pick_q;
              wr_st_q <= 16'(({16'b0, k_st} + {16'b0, size_q}) & 32'(AMask));
              wr_ln_q <= rem;
            end else begin
              gs_q <= k_ln;
              plan_q <= PRem;
              sh_idx_q <= CntW'(pick_q);
              sh_ptr_q <= CntW'(pick_q);
            end
          end
        end else begin
          if (size_q == '0 || f_end > {1'b0, pool_size_i}) status_q <= StBad;
          else if (has_prev && p_end > {1'b0, addr_q}) status_q <= StBad;
          else if (has_next && f_end > {1'b0, n_st}) status_q <= StBad;
          else if (has_prev && p_end == {1'b0, addr_q}) begin
            wr_q <= 1'b1; wr_idx_q <= posm_i; wr_st_q <= p_st;
            if (has_next && f_end == {1'b0, n_st}) begin
              wr_ln_q <= p_ln + size_q + n_ln;
              plan_q <= PRem; sh_idx_q <= pos_q; sh_ptr_q <= pos_q;
            end else wr_ln_q <= p_ln + size_q;
          end else if (has_next && f_end == {1'b0, n_st}) begin
            wr_q <= 1'b1; wr_idx_q <= pos_i; wr_st_q <= addr_q;
            wr_ln_q <= n_ln + size_q;
          end else if (cnt_q >= CntMax) status_q <= StFull;
          else begin
            wr_q <= 1'b1; wr_idx_q <= pos_i; wr_st_q <= addr_q; wr_ln_q <= size_q;
            plan_q <= PIns; sh_idx_q <= pos_q; sh_ptr_q <= cnt_q;
          end
        end
      end
      if (cmd_i.shift_step) begin
        if (plan_q == PRem) begin
          st_q[shi] <= st_q[shn];
          ln_q[shi] <= ln_q[shn];
          sh_ptr_q <= sh_ptr_q + 1'b1;
        end else begin
          st_q[shi] <= st_q[shi - 1'b1];
          ln_q[shi] <= ln_q[shi - 1'b1];
          sh_ptr_q <= sh_ptr_q - 1'b1;
        end
      end
      if (cmd_i.commit && wr_q) begin
        st_q[wr_idx_q] <= wr_st_q;
        ln_q[wr_idx_q] <= wr_ln_q;
      end
      if (cmd_i.commit) plan_q <= PNone;
    end
  end

  // remove with last entry: count drops in commit when no shift ran
  assign status_o     = status_q;
  assign grant_addr_o = ga_q;
  assign grant_size_o = gs_q;
endmodule

### rtl/core/variable_partition_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator
// free extent allocator with first, best and worst fit
// ----------------------------------------------------------------------------
// One item at a time. From acceptance to result valid an item passes the
// scan of S table entries (up to FreeSlots, the scan reads one entry a
// cycle), the decide step, the move of M entries when an extent is removed
// or inserted (up to FreeSlots, one a cycle) and the commit. Writing the pool
// size register reloads the table with one extent in the same cycle.
module variable_partition_allocator #(
  parameter int unsigned FreeSlots = vpa_pkg::FreeSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] block_addr_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic [15:0] grant_addr_o,
  output logic [15:0] grant_size_o,
  input  logic        cfg_we_i,
  input  logic [vpa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import vpa_pkg::*;

  logic [15:0] pool_size_q, min_slice_q;
  logic [1:0]  fit_q;
  logic        cfg_init;
  vpa_cmd_t    cmd;
  vpa_sts_t    sts;

  assign cfg_init = cfg_we_i && (cfg_idx_i == CfgMemSize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= MemSizeRst;
      min_slice_q <= MinSlRst;
      fit_q       <= FitFirst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMemSize: pool_size_q <= cfg_data_i;
        CfgFit:     fit_q       <= cfg_data_i[1:0];
        CfgMinSl:   min_slice_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .cfg_init_i(cfg_init), .cmd_o(cmd), .sts_i(sts)
  );

  vpa_dp #(.FreeSlots(FreeSlots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pool_size_i(cfg_init ? cfg_data_i : pool_size_q),
    .fit_policy_i(fit_q), .min_slice_i(min_slice_q),
    .mode_i, .req_size_i, .block_addr_i,
    .status_o, .grant_addr_o, .grant_size_o
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while busy");
  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status_o != StOk) |-> (grant_size_o == '0 && grant_addr_o == '0))
    else $error("grant on failed item");
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result without commit");
endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator testbench
// directed table then random allocate/free traffic, checked against a
// behavioral free extent table with fit policy, split and merge rules
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vpa_pkg::*;

  localparam int Slots    = 16;
  localparam int DirRows  = 22;
  localparam int RandGoal = 1500;
  localparam int IdleLimit = 20000;

  // register index with no register behind it, and the spare fit code
  localparam logic [CfgIdxW-1:0] CfgNone = 2'd3;
  localparam logic [1:0]         FitOther = 2'd3;

  typedef struct {
    logic        mode;
    logic [15:0] size;
    logic [15:0] addr;
    logic        known;
    logic [1:0]  st;
    logic [15:0] ga;
    logic [15:0] gs;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] ga;
    logic [15:0] gs;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [15:0] req_size;
  logic [15:0] block_addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] grant_addr;
  logic [15:0] grant_size;
  logic        cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [15:0] cfg_data;

  // predictor state
  int unsigned mdl_mem;
  logic [1:0]  mdl_fit;
  int unsigned mdl_min;
  int unsigned ext_base [Slots];
  int unsigned ext_len [Slots];
  int unsigned ext_cnt;

  grant_t      pending_grants[$];
  grant_t      known_grants[$];  // granted extents kept for later frees
  int          mismatches;
  int          idle_cycles;
  bit          hold_off_req;
  bit          rx_quiet;

  variable_partition_allocator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode_i      (mode),
    .req_size_i  (req_size),
    .block_addr_i(block_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status_o    (status),
    .grant_addr_o(grant_addr),
    .grant_size_o(grant_size),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void table_reload();
    ext_cnt = 0;
    for (int i = 0; i < Slots; i++) begin
      ext_base[i] = 0;
      ext_len[i]  = 0;
    end
    if (mdl_mem != 0) begin
      ext_len[0] = mdl_mem;
      ext_cnt    = 1;
    end
  endfunction

  function automatic void drop_extent(int unsigned k);
    for (int unsigned i = k; i + 1 < ext_cnt; i++) begin
      ext_base[i] = ext_base[i+1];
      ext_len[i]  = ext_len[i+1];
    end
    ext_cnt--;
    ext_base[ext_cnt] = 0;
    ext_len[ext_cnt]  = 0;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    case (idx)
      CfgMemSize: begin
        mdl_mem = val;
        table_reload();
      end
      CfgFit:   mdl_fit = val[1:0];
      CfgMinSl: mdl_min = val;
      default: ;
    endcase
  endfunction

  function automatic grant_t predict_grant(logic m, int unsigned sz, int unsigned ad);
    grant_t r;
    int unsigned pick, rem, pos, fin;
    bit found, jp, jn;
    r = '{st: StOk, ga: 16'd0, gs: 16'd0};
    pick = 0;
    found = 0;
    if (sz == 0) begin
      r.st = StBad;
      return r;
    end
    if (!m) begin
      for (int unsigned i = 0; i < ext_cnt; i++) begin
        if (ext_len[i] < sz) continue;
        if (!found) begin
          pick = i;
          found = 1;
          if (mdl_fit != FitBest && mdl_fit != FitWorst) break;
        end else if (mdl_fit == FitBest && ext_len[i] < ext_len[pick]) begin
          pick = i;
        end else if (mdl_fit == FitWorst && ext_len[i] > ext_len[pick]) begin
          pick = i;
        end
      end
      if (!found) begin
        r.st = StNoFit;
        return r;
      end
      rem = ext_len[pick] - sz;
      r.ga = ext_base[pick][15:0];
      if (rem > mdl_min) begin
        r.gs = sz[15:0];
        ext_base[pick] = (ext_base[pick] + sz) & 32'hFFFF;
        ext_len[pick] = rem;
      end else begin
        r.gs = ext_len[pick][15:0];
        drop_extent(pick);
      end
      return r;
    end
    fin = ad + sz;
    if (fin > mdl_mem) begin
      r.st = StBad;
      return r;
    end
    pos = 0;
    while (pos < ext_cnt && ext_base[pos] < ad) pos++;
    if ((pos > 0 && ext_base[pos-1] + ext_len[pos-1] > ad) ||
        (pos < ext_cnt && fin > ext_base[pos])) begin
      r.st = StBad;
      return r;
    end
    jp = pos > 0 && ext_base[pos-1] + ext_len[pos-1] == ad;
    jn = pos < ext_cnt && ext_base[pos] == fin;
    if (jp && jn) begin
      ext_len[pos-1] += sz + ext_len[pos];
      drop_extent(pos);
    end else if (jp) begin
      ext_len[pos-1] += sz;
    end else if (jn) begin
      ext_base[pos] = ad;
      ext_len[pos] += sz;
    end else begin
      if (ext_cnt >= Slots) begin
        r.st = StFull;
        return r;
      end
      for (int unsigned i = ext_cnt; i > pos; i--) begin
        ext_base[i] = ext_base[i-1];
        ext_len[i]  = ext_len[i-1];
      end
      ext_base[pos] = ad;
      ext_len[pos]  = sz;
      ext_cnt++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // receiver: random stall, with a long hold-off on request
  initial begin
    int n;
    out_stall = 1'b1;
    rx_quiet  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (rx_quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with none expected, status", status, -1);
      end else begin
        w = pending_grants.pop_front();
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (grant_addr !== w.ga) report_mismatch("grant_addr", grant_addr, w.ga);
        if (grant_size !== w.gs) report_mismatch("grant_size", grant_size, w.gs);
      end
    end
  end

  // watchdog on acceptance and result handshakes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(logic m, logic [15:0] sz, logic [15:0] ad, bit gaps);
    grant_t g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                           : $urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    req_size <= sz;
    block_addr <= ad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = predict_grant(m, sz, ad);
    pending_grants.push_back(g);
    if (!m && g.st == StOk) known_grants.push_back(g);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    if (idx == CfgMemSize) known_grants.delete();
    @(posedge clk);
  endtask

  dir_row_t dir_rows [DirRows];

  initial begin
    grant_t g;
    int     k, n;
    logic [15:0] sz;
    dir_rows = '{
      '{0, 16'd0,     16'd0, 1, StBad,   16'd0,   16'd0},
      '{1, 16'd0,     16'd5, 1, StBad,   16'd0,   16'd0},
      '{0, 16'd100,   16'd0, 1, StOk,    16'd0,   16'd100},
      '{0, 16'hFFFF,  16'd0, 1, StNoFit, 16'd0,   16'd0},
      '{0, 16'd200,   16'd0, 1, StOk,    16'd100, 16'd200},
      '{1, 16'd50,    16'd300, 1, StBad, 16'd0,   16'd0},
      '{1, 16'd10,  16'hFFFF, 1, StBad,  16'd0,   16'd0},
      '{1, 16'd100,   16'd0, 0, StOk,    16'd0,   16'd0},
      '{1, 16'd200,   16'd100, 0, StOk,  16'd0,   16'd0},
      '{0, 16'd1014,  16'd0, 1, StOk,    16'd0,   16'd1024},
      '{1, 16'd1014,  16'd0, 0, StOk,    16'd0,   16'd0},
      '{0, 16'd1013,  16'd0, 0, StOk,    16'd0,   16'd0},
      '{1, 16'd1024,  16'd0, 0, StOk,    16'd0,   16'd0},
      '{1, 16'd4,     16'd0, 0, StOk,    16'd0,   16'd0},
      '{0, 16'd1,     16'd0, 0, StOk,    16'd0,   16'd0},
      '{0, 16'd20,    16'd0, 0, StOk,    16'd0,   16'd0},
      '{0, 16'd20,    16'd0, 0, StOk,    16'd0,   16'd0},
      '{1, 16'd10,    16'd1, 0, StOk,    16'd0,   16'd0},
      '{1, 16'd5,     16'd30, 0, StOk,   16'd0,   16'd0},
      '{0, 16'd3,     16'd0, 0, StOk,    16'd0,   16'd0},
      '{0, 16'd900,   16'd0, 0, StOk,    16'd0,   16'd0},
      '{1, 16'd24,    16'd1000, 0, StOk, 16'd0,   16'd0}
    };
    rst_n = 1'b0;
    in_valid = 1'b0;
    mode = 1'b0;
    req_size = '0;
    block_addr = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    mismatches = 0;
    hold_off_req = 1'b0;
    mdl_mem = MemSizeRst;
    mdl_fit = FitFirst;
    mdl_min = MinSlRst;
    table_reload();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows from reset defaults
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].size, dir_rows[i].addr, 1'b0);
      if (dir_rows[i].known) begin
        g = '{st: dir_rows[i].st, ga: dir_rows[i].ga, gs: dir_rows[i].gs};
        if (pending_grants[$] != g) report_mismatch("directed row", i, -1);
      end
    end
    drain();

    // memory size zero and unused register index
    write_reg(CfgMemSize, 16'd0);
    write_reg(CfgNone, 16'hFFFF);
    send_item(0, 16'd1, 16'd0, 1'b0);
    send_item(1, 16'd1, 16'd0, 1'b0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CfgMemSize, 16'hFFFF); write_reg(CfgFit, FitFirst);
                 write_reg(CfgMinSl, 16'd0); end
        1: begin write_reg(CfgMemSize, 16'd512); write_reg(CfgFit, FitBest);
                 write_reg(CfgMinSl, 16'd4); end
        2: begin write_reg(CfgMemSize, 16'd2000); write_reg(CfgFit, FitWorst);
                 write_reg(CfgMinSl, 16'd10); end
        3: begin write_reg(CfgMemSize, 16'd1); write_reg(CfgFit, FitOther);
                 write_reg(CfgMinSl, 16'hFFFF); end
        4: begin write_reg(CfgMemSize, 16'd300); write_reg(CfgFit, FitOther);
                 write_reg(CfgMinSl, 16'd1); end
        5: begin write_reg(CfgMemSize, 16'd4096); write_reg(CfgFit, FitBest);
                 write_reg(CfgMinSl, 16'd0); end
        6: begin write_reg(CfgMemSize, 16'hAAAA); write_reg(CfgFit, FitWorst);
                 write_reg(CfgMinSl, 16'h5555); end
        default: begin write_reg(CfgMemSize, 16'd800); write_reg(CfgFit, FitFirst);
                 write_reg(CfgMinSl, 16'd2); end
      endcase
      rx_quiet = (ph == 5);
      if (ph == 2) hold_off_req = 1'b1;
      for (int it = 0; it < RandGoal / 8; it++) begin
        if (it == 90) begin
          // sender waits for every result
          drain();
        end
        n = $urandom_range(0, 9);
        if (n < 4) begin
          sz = (ph == 6 && $urandom_range(0, 3) == 0) ? 16'($urandom())
               : 16'($urandom_range(1, mdl_mem / 8 + 2));
          send_item(0, sz, 16'($urandom()), 1'b1);
        end else if (n < 8 && known_grants.size() != 0) begin
          k = $urandom_range(0, known_grants.size() - 1);
          g = known_grants[k];
          known_grants.delete(k);
          send_item(1, g.gs, g.ga, 1'b1);
        end else if (n == 8) begin
          send_item(1, 16'($urandom_range(0, mdl_mem + 2)),
                    16'($urandom_range(0, mdl_mem)), 1'b1);
        end else begin
          send_item($urandom_range(0, 1), 16'($urandom()), 16'($urandom()), 1'b1);
        end
      end
      drain();
    end
    rx_quiet = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### variable_partition_allocator.f
rtl/core/vpa_pkg.sv
rtl/core/vpa_ctrl.sv
rtl/core/vpa_dp.sv
rtl/core/variable_partition_allocator.sv
dv/testbench.sv
